[sv/gso_pkg.sv]
package gso_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IW  = 32;               // input entry width
  localparam int OW  = 18;               // output entry width
  localparam int VW  = 36;               // signed column entry after projection removal
  localparam int MW  = VW;               // magnitude width
  localparam int SW  = 2 * MW + 2;       // sum of three squares
  localparam int PW  = SW + 2 * FRAC_BITS + 4;
  localparam int KW  = FRAC_BITS + 1;    // unsigned normalized magnitude, up to ONE
  localparam int NST = FRAC_BITS + 1;    // one result bit per stage
  localparam int DW  = 36;               // dot product after the shift
  localparam int PAW = OW + IW;          // unit entry times input entry
  localparam int DSW = PAW + 2;          // sum of three such products
  localparam int PCW = DW + OW;          // dot times unit entry
  localparam int PSW = PCW + 1;          // sum of two such products
  localparam int IN_DW  = 9 * IW;
  localparam int OUT_DW = ((9 * OW + 7) / 8) * 8;

  typedef logic [VW-1:0] vw_t;
  typedef vw_t [2:0] vec_t;
  typedef logic [OW-1:0] q_t;
  typedef q_t [2:0] qvec_t;

  // Everything an item carries down the pipeline besides the column in work.
  typedef struct packed {
    logic [8:0][IW-1:0] m;
    qvec_t q0;
    qvec_t q1;
    logic deg;
  } ctx_t;

endpackage

[sv/gso_norm.sv]
module gso_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  gso_pkg::vec_t in_v,
  input  gso_pkg::ctx_t in_ctx,
  output logic          out_valid,
  output gso_pkg::qvec_t out_q,
  output logic          out_zero,
  output gso_pkg::ctx_t out_ctx
);
  import gso_pkg::*;

  logic [2*MW-1:0] sq_nxt [3];
  logic [MW-1:0]   mag [3];
  logic [2*MW-1:0] sq_a_r [3];
  logic            neg_a_r [3];
  ctx_t            ctx_a_r;
  logic            vld_a_r;

  logic [PW-1:0] p_r   [NST+1][3];
  logic [PW-1:0] qq_r  [NST+1][3];
  logic [PW-1:0] rhs_r [NST+1][3];
  logic [KW-1:0] k_r   [NST+1][3];
  logic          neg_r [NST+1][3];
  logic [SW-1:0] s_r   [NST+1];
  ctx_t          ctx_r [NST+1];
  logic          vld_r [NST+1];

  logic [PW-1:0] p_nxt  [NST][3];
  logic [PW-1:0] qq_nxt [NST][3];
  logic [KW-1:0] k_nxt  [NST][3];
  logic [PW-1:0] cand   [NST][3];
  logic [PW-1:0] sx     [NST];
  logic [SW-1:0] s_sum;

  qvec_t q_nxt;
  qvec_t q_r;
  logic  zero_r;
  ctx_t  ctx_o_r;
  logic  vld_o_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = in_v[i][VW-1] ? (~in_v[i] + VW'(1)) : in_v[i];
      sq_nxt[i] = mag[i] * mag[i];
    end
    s_sum = SW'(sq_a_r[0]) + SW'(sq_a_r[1]) + SW'(sq_a_r[2]);
  end

  // Restoring search for k = floor(|v| * ONE / sqrt(s)): p holds s*k*k and
  // qq holds s*k, so trying one more bit needs only shifts and adds.
  always_comb begin
    for (int j = 0; j < NST; j++) begin
      sx[j] = PW'(s_r[j]);
      for (int i = 0; i < 3; i++) begin
        cand[j][i] = p_r[j][i] + (qq_r[j][i] << (FRAC_BITS - j + 1))
                   + (sx[j] << (2 * (FRAC_BITS - j)));
        if (cand[j][i] <= rhs_r[j][i]) begin
          p_nxt[j][i]  = cand[j][i];
          qq_nxt[j][i] = qq_r[j][i] + (sx[j] << (FRAC_BITS - j));
          k_nxt[j][i]  = k_r[j][i] | (KW'(1) << (FRAC_BITS - j));
        end else begin
          p_nxt[j][i]  = p_r[j][i];
          qq_nxt[j][i] = qq_r[j][i];
          k_nxt[j][i]  = k_r[j][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s_r[NST] == '0) begin
        q_nxt[i] = '0;
      end else if (neg_r[NST][i]) begin
        q_nxt[i] = ~OW'(k_r[NST][i]) + OW'(1);
      end else begin
        q_nxt[i] = OW'(k_r[NST][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_o_r <= 1'b0;
      for (int j = 0; j <= NST; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_a_r  <= in_valid;
      vld_r[0] <= vld_a_r;
      for (int j = 0; j < NST; j++) vld_r[j+1] <= vld_r[j];
      vld_o_r  <= vld_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_a_r[i]   <= sq_nxt[i];
        neg_a_r[i]  <= in_v[i][VW-1];
        p_r[0][i]   <= '0;
        qq_r[0][i]  <= '0;
        k_r[0][i]   <= '0;
        rhs_r[0][i] <= PW'(sq_a_r[i]) << (2 * FRAC_BITS);
        neg_r[0][i] <= neg_a_r[i];
      end
      ctx_a_r  <= in_ctx;
      s_r[0]   <= s_sum;
      ctx_r[0] <= ctx_a_r;
      for (int j = 0; j < NST; j++) begin
        for (int i = 0; i < 3; i++) begin
          p_r[j+1][i]   <= p_nxt[j][i];
          qq_r[j+1][i]  <= qq_nxt[j][i];
          k_r[j+1][i]   <= k_nxt[j][i];
          rhs_r[j+1][i] <= rhs_r[j][i];
          neg_r[j+1][i] <= neg_r[j][i];
        end
        s_r[j+1]   <= s_r[j];
        ctx_r[j+1] <= ctx_r[j];
      end
      q_r     <= q_nxt;
      zero_r  <= (s_r[NST] == '0);
      ctx_o_r <= ctx_r[NST];
    end
  end

  assign out_valid = vld_o_r;
  assign out_q     = q_r;
  assign out_zero  = zero_r;
  assign out_ctx   = ctx_o_r;

endmodule

[sv/gram_schmidt_orthonormalize_3x3.sv]
// Classical Gram-Schmidt orthonormalization of one 3x3 matrix per transaction.
// Input channel in_*: nine signed Q16.16 entries, row-major, 32 bits each.
// Output channel out_*: nine signed 18-bit Q2.16 orthonormal entries in the
// same order, plus out_tuser, set when some column had zero length; that
// column is returned as zeros and removes nothing from later columns.
// Each of the three column normalizations is a pipelined bit-per-stage search
// of FRAC_BITS + 1 stages, and the projections for the second and third
// columns take four stages each.
// Throughput is one matrix per cycle while the receiver does not stall; a new
// transaction may then be accepted on every clock edge.
// When the receiver stalls, the whole pipeline holds and in_tready falls;
// empty stages are not squeezed out, and nothing is dropped or repeated.
// in_tready is high whenever the output register is empty or being taken.
// Reset clears all valid bits; no matrix data is kept between transactions.
module gram_schmidt_orthonormalize_3x3 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // in_r0c0, in_r0c1, in_r0c2, in_r1c0, ..., in_r2c2 (32 bits each)
  input  logic [gso_pkg::IN_DW-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_r0c0, out_r0c1, ..., out_r2c2 (18 bits each), then zero padding
  output logic [gso_pkg::OUT_DW-1:0] out_tdata,
  // degenerate
  output logic                       out_tuser
);
  import gso_pkg::*;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  ctx_t ctx_in_r;
  logic vld_in_r;
  vec_t v0, v1, v2;

  logic  n0_vld, n0_zero, n1_vld, n1_zero, n2_vld, n2_zero;
  qvec_t n0_q, n1_q, n2_q;
  ctx_t  n0_ctx, n1_ctx, n2_ctx;

  // Column 1 projection stages.
  ctx_t ctx_a_r, ctx_b_r, ctx_c_r, ctx_d_r;
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r;
  logic signed [PAW-1:0] pa_r [3];
  logic signed [DSW-1:0] dsum_b;
  logic signed [DW-1:0]  db_r;
  logic signed [PCW-1:0] pc_r [3];
  vec_t v1_r;

  // Column 2 projection stages.
  ctx_t ctx_e_r, ctx_f_r, ctx_g_r, ctx_h_r;
  logic vld_e_r, vld_f_r, vld_g_r, vld_h_r;
  logic signed [PAW-1:0] pe0_r [3];
  logic signed [PAW-1:0] pe1_r [3];
  logic signed [DSW-1:0] dsum_f0, dsum_f1;
  logic signed [DW-1:0]  df0_r, df1_r;
  logic signed [PCW-1:0] pg0_r [3];
  logic signed [PCW-1:0] pg1_r [3];
  logic signed [PSW-1:0] psum_h [3];
  vec_t v2_r;

  ctx_t n0_ctx_upd, n1_ctx_upd;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      v0[r] = VW'($signed(ctx_in_r.m[3*r]));
    end
    n0_ctx_upd     = n0_ctx;
    n0_ctx_upd.q0  = n0_q;
    n0_ctx_upd.deg = n0_ctx.deg | n0_zero;
    n1_ctx_upd     = n1_ctx;
    n1_ctx_upd.q1  = n1_q;
    n1_ctx_upd.deg = n1_ctx.deg | n1_zero;
    dsum_b  = DSW'(pa_r[0]) + DSW'(pa_r[1]) + DSW'(pa_r[2]);
    dsum_f0 = DSW'(pe0_r[0]) + DSW'(pe0_r[1]) + DSW'(pe0_r[2]);
    dsum_f1 = DSW'(pe1_r[0]) + DSW'(pe1_r[1]) + DSW'(pe1_r[2]);
    for (int r = 0; r < 3; r++) begin
      psum_h[r] = PSW'(pg0_r[r]) + PSW'(pg1_r[r]);
    end
    v1 = v1_r;
    v2 = v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_in_r <= 1'b0;
      vld_a_r  <= 1'b0;
      vld_b_r  <= 1'b0;
      vld_c_r  <= 1'b0;
      vld_d_r  <= 1'b0;
      vld_e_r  <= 1'b0;
      vld_f_r  <= 1'b0;
      vld_g_r  <= 1'b0;
      vld_h_r  <= 1'b0;
    end else if (en) begin
      vld_in_r <= in_tvalid;
      vld_a_r  <= n0_vld;
      vld_b_r  <= vld_a_r;
      vld_c_r  <= vld_b_r;
      vld_d_r  <= vld_c_r;
      vld_e_r  <= n1_vld;
      vld_f_r  <= vld_e_r;
      vld_g_r  <= vld_f_r;
      vld_h_r  <= vld_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_in_r.m   <= in_tdata;
      ctx_in_r.q0  <= '0;
      ctx_in_r.q1  <= '0;
      ctx_in_r.deg <= 1'b0;

      ctx_a_r <= n0_ctx_upd;
      for (int r = 0; r < 3; r++) begin
        pa_r[r] <= $signed(n0_q[r]) * $signed(n0_ctx.m[3*r+1]);
      end
      ctx_b_r <= ctx_a_r;
      db_r    <= DW'(dsum_b >>> FRAC_BITS);
      ctx_c_r <= ctx_b_r;
      for (int r = 0; r < 3; r++) begin
        pc_r[r] <= db_r * $signed(ctx_b_r.q0[r]);
      end
      ctx_d_r <= ctx_c_r;
      for (int r = 0; r < 3; r++) begin
        v1_r[r] <= VW'($signed(ctx_c_r.m[3*r+1])) - VW'(pc_r[r] >>> FRAC_BITS);
      end

      ctx_e_r <= n1_ctx_upd;
      for (int r = 0; r < 3; r++) begin
        pe0_r[r] <= $signed(n1_ctx.q0[r]) * $signed(n1_ctx.m[3*r+2]);
        pe1_r[r] <= $signed(n1_q[r]) * $signed(n1_ctx.m[3*r+2]);
      end
      ctx_f_r <= ctx_e_r;
      df0_r   <= DW'(dsum_f0 >>> FRAC_BITS);
      df1_r   <= DW'(dsum_f1 >>> FRAC_BITS);
      ctx_g_r <= ctx_f_r;
      for (int r = 0; r < 3; r++) begin
        pg0_r[r] <= df0_r * $signed(ctx_f_r.q0[r]);
        pg1_r[r] <= df1_r * $signed(ctx_f_r.q1[r]);
      end
      ctx_h_r <= ctx_g_r;
      for (int r = 0; r < 3; r++) begin
        v2_r[r] <= VW'($signed(ctx_g_r.m[3*r+2])) - VW'(psum_h[r] >>> FRAC_BITS);
      end
    end
  end

  gso_norm u_norm0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_in_r),
    .in_v      (v0),
    .in_ctx    (ctx_in_r),
    .out_valid (n0_vld),
    .out_q     (n0_q),
    .out_zero  (n0_zero),
    .out_ctx   (n0_ctx)
  );

  gso_norm u_norm1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_d_r),
    .in_v      (v1),
    .in_ctx    (ctx_d_r),
    .out_valid (n1_vld),
    .out_q     (n1_q),
    .out_zero  (n1_zero),
    .out_ctx   (n1_ctx)
  );

  gso_norm u_norm2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_h_r),
    .in_v      (v2),
    .in_ctx    (ctx_h_r),
    .out_valid (n2_vld),
    .out_q     (n2_q),
    .out_zero  (n2_zero),
    .out_ctx   (n2_ctx)
  );

  // The last normalizer stage is the output register.
  always_comb begin
    out_tdata = '0;
    for (int r = 0; r < 3; r++) begin
      out_tdata[(3*r)*OW +: OW]   = n2_ctx.q0[r];
      out_tdata[(3*r+1)*OW +: OW] = n2_ctx.q1[r];
      out_tdata[(3*r+2)*OW +: OW] = n2_q[r];
    end
  end

  assign out_tvalid = n2_vld;
  assign out_tuser  = n2_ctx.deg | n2_zero;

endmodule
